// ===== design/mrd_pkg.sv =====
// Shared types, codes and constants for the mirror request dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package mrd_pkg;

   localparam int MAX_DISKS_DEFAULT   = 8;
   localparam int MAX_PENDING_DEFAULT = 63;
   localparam int QUEUE_DEPTH         = 2;

   localparam int TYPE_W   = 3;
   localparam int DISK_W   = 16;
   localparam int REQID_W  = 32;
   localparam int SRCID_W  = 8;
   localparam int STATUS_W = 3;
   localparam int MASK_W   = 8;
   localparam int SLOTO_W  = 3;

   localparam logic [TYPE_W-1:0] REQ_ATTACH     = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_READ       = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_WRITE      = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_READ_DONE  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_WRITE_DONE = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_MARK_READY = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_DETACH     = 3'd6;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_READY   = 3'd1,
      ST_QUEUE_FULL = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_UNKNOWN    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ATTACH,
      OP_READ,
      OP_WRITE,
      OP_READ_DONE,
      OP_WRITE_DONE,
      OP_MARK_READY,
      OP_DETACH,
      OP_OTHER
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [DISK_W-1:0]    disk_id;
      logic [REQID_W-1:0]   transfer_id;
      logic [SRCID_W-1:0]   requester_id;
   } cmd_type;

   function automatic logic [SLOTO_W-1:0] slot_to_port(input logic [31:0] slot);
      return slot[SLOTO_W-1:0];
   endfunction

   function automatic logic [MASK_W-1:0] mask_to_port(input logic [31:0] mask);
      return mask[MASK_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/mirror_request_dispatcher.sv =====
// Top level of the mirror request dispatcher.
// The dispatcher keeps a table of attached mirror disks and steers each request: a write goes
// to every ready disk, a read to the ready disk with the fewest pending requests, and a detach
// redistributes the detached disk's pending reads before its final result. Requests pass
// through a two-entry queue to the execution unit, whose table lookups and least-loaded
// compare tree are registered before each update; a detach takes an evaluate and a move
// step for each pending read that it moves. Results leave through an output register, and new
// requests are queued while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module mirror_request_dispatcher #(
   parameter int MAX_DISKS   = mrd_pkg::MAX_DISKS_DEFAULT,
   parameter int MAX_PENDING = mrd_pkg::MAX_PENDING_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [mrd_pkg::TYPE_W-1:0]    req_type,
   input  wire logic [mrd_pkg::DISK_W-1:0]    req_disk_id,
   input  wire logic [mrd_pkg::REQID_W-1:0]   req_transfer_id,
   input  wire logic [mrd_pkg::SRCID_W-1:0]   req_requester_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mrd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [mrd_pkg::MASK_W-1:0]         rsp_target_mask,
   output logic [mrd_pkg::SLOTO_W-1:0]        rsp_target_slot,
   output logic [mrd_pkg::REQID_W-1:0]        rsp_echo_request,
   output logic [mrd_pkg::SRCID_W-1:0]        rsp_echo_requester,
   output logic                               rsp_is_move,
   output logic                               rsp_last
);

   logic             push_valid, push_ready;
   mrd_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   mrd_pkg::cmd_type pop_cmd;

   mrd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_disk_id      (req_disk_id),
      .req_transfer_id  (req_transfer_id),
      .req_requester_id (req_requester_id),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_cmd         (push_cmd)
   );

   mrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   mrd_back #(
      .MAX_DISKS   (MAX_DISKS),
      .MAX_PENDING (MAX_PENDING)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (pop_valid),
      .cmd_pop            (pop_ready),
      .cmd                (pop_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_target_mask    (rsp_target_mask),
      .rsp_target_slot    (rsp_target_slot),
      .rsp_echo_request   (rsp_echo_request),
      .rsp_echo_requester (rsp_echo_requester),
      .rsp_is_move        (rsp_is_move),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

// ===== design/mrd_front.sv =====
// Front end: accepts requests and classifies them into queued commands.
`timescale 1ns / 1ps
`default_nettype none

module mrd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mrd_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [mrd_pkg::DISK_W-1:0]   req_disk_id,
   input  wire logic [mrd_pkg::REQID_W-1:0]  req_transfer_id,
   input  wire logic [mrd_pkg::SRCID_W-1:0]  req_requester_id,
   output logic                              push_valid,
   input  wire logic                         push_ready,
   output mrd_pkg::cmd_type                  push_cmd
);

   mrd_pkg::op_type op;
   logic            seen_ff;
   logic            seen_in;

   always_comb begin
      case (req_type)
         mrd_pkg::REQ_ATTACH:     op = mrd_pkg::OP_ATTACH;
         mrd_pkg::REQ_READ:       op = mrd_pkg::OP_READ;
         mrd_pkg::REQ_WRITE:      op = mrd_pkg::OP_WRITE;
         mrd_pkg::REQ_READ_DONE:  op = mrd_pkg::OP_READ_DONE;
         mrd_pkg::REQ_WRITE_DONE: op = mrd_pkg::OP_WRITE_DONE;
         mrd_pkg::REQ_MARK_READY: op = mrd_pkg::OP_MARK_READY;
         mrd_pkg::REQ_DETACH:     op = mrd_pkg::OP_DETACH;
         default:                 op = mrd_pkg::OP_OTHER;
      endcase
   end

   // Requests are held off out of reset until the seen register has been set.
   assign seen_in    = 1'b1;
   assign req_ready  = push_ready && seen_ff;
   assign push_valid = req_valid && seen_ff;

   always_comb begin
      push_cmd.op           = op;
      push_cmd.disk_id      = req_disk_id;
      push_cmd.transfer_id  = req_transfer_id;
      push_cmd.requester_id = req_requester_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mrd_queue.sv =====
// Short command queue between the front end and the execution unit.
`timescale 1ns / 1ps
`default_nettype none

module mrd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire mrd_pkg::cmd_type  push_cmd,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output mrd_pkg::cmd_type       pop_cmd
);

   localparam int PTR_W = (mrd_pkg::QUEUE_DEPTH > 1) ? $clog2(mrd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mrd_pkg::QUEUE_DEPTH + 1);

   mrd_pkg::cmd_type entry_ff [mrd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(mrd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(mrd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(mrd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mrd_back.sv =====
// Execution unit: disk table, least-loaded selection and result register.
`timescale 1ns / 1ps
`default_nettype none

module mrd_back #(
   parameter int MAX_DISKS   = mrd_pkg::MAX_DISKS_DEFAULT,
   parameter int MAX_PENDING = mrd_pkg::MAX_PENDING_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          cmd_valid,
   output logic                               cmd_pop,
   input  wire mrd_pkg::cmd_type              cmd,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mrd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [mrd_pkg::MASK_W-1:0]         rsp_target_mask,
   output logic [mrd_pkg::SLOTO_W-1:0]        rsp_target_slot,
   output logic [mrd_pkg::REQID_W-1:0]        rsp_echo_request,
   output logic [mrd_pkg::SRCID_W-1:0]        rsp_echo_requester,
   output logic                               rsp_is_move,
   output logic                               rsp_last
);

   localparam int SLOT_W = $clog2(MAX_DISKS);
   localparam int CNT_W  = $clog2(MAX_PENDING + 1);
   localparam int LOAD_W = CNT_W + 1;
   localparam int NP     = 1 << SLOT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_APPLY,
      S_MOVE,
      S_FINAL
   } state_type;

   // Disk table.
   logic [MAX_DISKS-1:0] used_ff, used_in;
   logic [MAX_DISKS-1:0] ready_ff, ready_in;
   logic [mrd_pkg::DISK_W-1:0] disk_ff [MAX_DISKS];
   logic [mrd_pkg::DISK_W-1:0] disk_in [MAX_DISKS];
   logic [CNT_W-1:0] rd_ff [MAX_DISKS];
   logic [CNT_W-1:0] rd_in [MAX_DISKS];
   logic [CNT_W-1:0] wr_ff [MAX_DISKS];
   logic [CNT_W-1:0] wr_in [MAX_DISKS];

   // Sequencer.
   state_type        state_ff, state_in;
   mrd_pkg::cmd_type cmd_ff, cmd_in;
   logic             moving_ff, moving_in;
   logic [CNT_W-1:0] moves_ff, moves_in;
   logic [SLOT_W-1:0] det_slot_ff, det_slot_in;

   // Registered table evaluation.
   logic [SLOT_W-1:0]    hit_slot_in, hit_slot_ff;
   logic                 hit_found_in, hit_found_ff;
   logic [SLOT_W-1:0]    free_slot_in, free_slot_ff;
   logic                 free_found_in, free_found_ff;
   logic                 empty_in, empty_ff;
   logic [MAX_DISKS-1:0] rdy_mask_in, rdy_mask_ff;
   logic                 wfull_in, wfull_ff;
   logic [SLOT_W-1:0]    best_slot_ff;
   logic                 best_found_ff;

   // Least-loaded compare tree.
   logic [LOAD_W-1:0] tl [SLOT_W+1][NP];
   logic [SLOT_W-1:0] ti [SLOT_W+1][NP];
   logic              tv [SLOT_W+1][NP];

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mrd_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [mrd_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic [mrd_pkg::SLOTO_W-1:0]  slot_ff, slot_in;
   logic [mrd_pkg::REQID_W-1:0]  echo_req_ff, echo_req_in;
   logic [mrd_pkg::SRCID_W-1:0]  echo_src_ff, echo_src_in;
   logic                         move_ff, move_in;
   logic                         last_ff, last_in;

   logic out_free;
   logic advance;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      hit_slot_in   = '0;
      hit_found_in  = 1'b0;
      free_slot_in  = '0;
      free_found_in = 1'b0;
      wfull_in      = 1'b0;
      for (int i = MAX_DISKS - 1; i >= 0; i--) begin
         if (used_ff[i] && (disk_ff[i] == cmd_ff.disk_id)) begin
            hit_found_in = 1'b1;
            hit_slot_in  = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            free_found_in = 1'b1;
            free_slot_in  = SLOT_W'(i);
         end
      end
      rdy_mask_in = used_ff & ready_ff;
      empty_in    = (used_ff == '0);
      for (int i = 0; i < MAX_DISKS; i++) begin
         if (rdy_mask_in[i] && (wr_ff[i] >= CNT_W'(MAX_PENDING))) begin
            wfull_in = 1'b1;
         end
      end
   end

   always_comb begin
      logic take_b;
      for (int l = 0; l <= SLOT_W; l++) begin
         for (int n = 0; n < NP; n++) begin
            tl[l][n] = '0;
            ti[l][n] = '0;
            tv[l][n] = 1'b0;
         end
      end
      for (int n = 0; n < MAX_DISKS; n++) begin
         tv[0][n] = used_ff[n] && ready_ff[n];
         tl[0][n] = LOAD_W'(rd_ff[n]) + LOAD_W'(wr_ff[n]);
         ti[0][n] = SLOT_W'(n);
      end
      for (int l = 0; l < SLOT_W; l++) begin
         for (int n = 0; n < (NP >> (l + 1)); n++) begin
            take_b = tv[l][2*n+1] && (!tv[l][2*n] || (tl[l][2*n+1] < tl[l][2*n]));
            tv[l+1][n] = take_b ? tv[l][2*n+1] : tv[l][2*n];
            tl[l+1][n] = take_b ? tl[l][2*n+1] : tl[l][2*n];
            ti[l+1][n] = take_b ? ti[l][2*n+1] : ti[l][2*n];
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      moving_in   = moving_ff;
      moves_in    = moves_ff;
      det_slot_in = det_slot_ff;
      used_in     = used_ff;
      ready_in    = ready_ff;
      disk_in     = disk_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      cmd_pop     = 1'b0;
      advance     = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      mask_in      = mask_ff;
      slot_in      = slot_ff;
      echo_req_in  = echo_req_ff;
      echo_src_in  = echo_src_ff;
      move_in      = move_ff;
      last_in      = last_ff;

      case (state_ff)
         S_IDLE: begin
            advance = 1'b1;
         end
         S_EVAL: begin
            state_in = moving_ff ? S_MOVE : S_APPLY;
         end
         S_APPLY: begin
            if (out_free) begin
               advance      = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = mrd_pkg::ST_OK;
               mask_in      = '0;
               slot_in      = '0;
               echo_req_in  = cmd_ff.transfer_id;
               echo_src_in  = cmd_ff.requester_id;
               move_in      = 1'b0;
               last_in      = 1'b1;
               case (cmd_ff.op)
                  mrd_pkg::OP_ATTACH: begin
                     if (free_found_ff) begin
                        used_in[free_slot_ff]  = 1'b1;
                        ready_in[free_slot_ff] = empty_ff;
                        disk_in[free_slot_ff]  = cmd_ff.disk_id;
                        rd_in[free_slot_ff]    = '0;
                        wr_in[free_slot_ff]    = '0;
                        mask_in = mrd_pkg::mask_to_port(32'(1) << free_slot_ff);
                        slot_in = mrd_pkg::slot_to_port(32'(free_slot_ff));
                     end else begin
                        status_in = mrd_pkg::ST_TABLE_FULL;
                     end
                  end
                  mrd_pkg::OP_READ: begin
                     if (!best_found_ff) begin
                        status_in = mrd_pkg::ST_NO_READY;
                     end else if (rd_ff[best_slot_ff] >= CNT_W'(MAX_PENDING)) begin
                        status_in = mrd_pkg::ST_QUEUE_FULL;
                        slot_in   = mrd_pkg::slot_to_port(32'(best_slot_ff));
                     end else begin
                        rd_in[best_slot_ff] = rd_ff[best_slot_ff] + 1'b1;
                        mask_in = mrd_pkg::mask_to_port(32'(1) << best_slot_ff);
                        slot_in = mrd_pkg::slot_to_port(32'(best_slot_ff));
                     end
                  end
                  mrd_pkg::OP_WRITE: begin
                     if (rdy_mask_ff == '0) begin
                        status_in = mrd_pkg::ST_NO_READY;
                     end else if (wfull_ff) begin
                        status_in = mrd_pkg::ST_QUEUE_FULL;
                     end else begin
                        for (int i = 0; i < MAX_DISKS; i++) begin
                           if (rdy_mask_ff[i]) begin
                              wr_in[i] = wr_ff[i] + 1'b1;
                           end
                        end
                        mask_in = mrd_pkg::mask_to_port(32'(rdy_mask_ff));
                     end
                  end
                  mrd_pkg::OP_READ_DONE, mrd_pkg::OP_WRITE_DONE,
                  mrd_pkg::OP_MARK_READY: begin
                     if (!hit_found_ff) begin
                        status_in = mrd_pkg::ST_UNKNOWN;
                     end else begin
                        slot_in = mrd_pkg::slot_to_port(32'(hit_slot_ff));
                        if (cmd_ff.op == mrd_pkg::OP_READ_DONE) begin
                           if (rd_ff[hit_slot_ff] != '0) begin
                              rd_in[hit_slot_ff] = rd_ff[hit_slot_ff] - 1'b1;
                           end
                        end else if (cmd_ff.op == mrd_pkg::OP_WRITE_DONE) begin
                           if (wr_ff[hit_slot_ff] != '0) begin
                              wr_in[hit_slot_ff] = wr_ff[hit_slot_ff] - 1'b1;
                           end
                        end else begin
                           ready_in[hit_slot_ff] = 1'b1;
                        end
                     end
                  end
                  mrd_pkg::OP_DETACH: begin
                     if (!hit_found_ff) begin
                        status_in = mrd_pkg::ST_UNKNOWN;
                     end else begin
                        advance               = 1'b0;
                        rsp_valid_in          = rsp_valid_ff && !rsp_ready;
                        status_in             = status_ff;
                        mask_in               = mask_ff;
                        slot_in               = slot_ff;
                        echo_req_in           = echo_req_ff;
                        echo_src_in           = echo_src_ff;
                        move_in               = move_ff;
                        last_in               = last_ff;
                        used_in[hit_slot_ff]  = 1'b0;
                        ready_in[hit_slot_ff] = 1'b0;
                        rd_in[hit_slot_ff]    = '0;
                        wr_in[hit_slot_ff]    = '0;
                        moves_in              = rd_ff[hit_slot_ff];
                        det_slot_in           = hit_slot_ff;
                        if (rd_ff[hit_slot_ff] != '0) begin
                           moving_in = 1'b1;
                           state_in  = S_EVAL;
                        end else begin
                           state_in  = S_FINAL;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MOVE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = mrd_pkg::ST_OK;
               mask_in      = '0;
               slot_in      = '0;
               echo_req_in  = '0;
               echo_src_in  = '0;
               move_in      = 1'b1;
               last_in      = 1'b0;
               if (!best_found_ff) begin
                  status_in = mrd_pkg::ST_NO_READY;
               end else if (rd_ff[best_slot_ff] >= CNT_W'(MAX_PENDING)) begin
                  status_in = mrd_pkg::ST_QUEUE_FULL;
                  slot_in   = mrd_pkg::slot_to_port(32'(best_slot_ff));
               end else begin
                  rd_in[best_slot_ff] = rd_ff[best_slot_ff] + 1'b1;
                  mask_in = mrd_pkg::mask_to_port(32'(1) << best_slot_ff);
                  slot_in = mrd_pkg::slot_to_port(32'(best_slot_ff));
               end
               moves_in = moves_ff - 1'b1;
               if (moves_ff == CNT_W'(1)) begin
                  moving_in = 1'b0;
                  state_in  = S_FINAL;
               end else begin
                  state_in  = S_EVAL;
               end
            end
         end
         S_FINAL: begin
            if (out_free) begin
               advance      = 1'b1;
               rsp_valid_in = 1'b1;
               status_in    = mrd_pkg::ST_OK;
               mask_in      = '0;
               slot_in      = mrd_pkg::slot_to_port(32'(det_slot_ff));
               echo_req_in  = cmd_ff.transfer_id;
               echo_src_in  = cmd_ff.requester_id;
               move_in      = 1'b0;
               last_in      = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (cmd_valid) begin
            cmd_pop  = 1'b1;
            cmd_in   = cmd;
            state_in = S_EVAL;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      moves_ff      <= moves_in;
      det_slot_ff   <= det_slot_in;
      hit_slot_ff   <= hit_slot_in;
      hit_found_ff  <= hit_found_in;
      free_slot_ff  <= free_slot_in;
      free_found_ff <= free_found_in;
      empty_ff      <= empty_in;
      rdy_mask_ff   <= rdy_mask_in;
      wfull_ff      <= wfull_in;
      best_slot_ff  <= ti[SLOT_W][0];
      best_found_ff <= tv[SLOT_W][0];
      status_ff     <= status_in;
      mask_ff       <= mask_in;
      slot_ff       <= slot_in;
      echo_req_ff   <= echo_req_in;
      echo_src_ff   <= echo_src_in;
      move_ff       <= move_in;
      last_ff       <= last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      disk_ff <= disk_in;
      if (reset) begin
         used_ff  <= '0;
         ready_ff <= '0;
         for (int i = 0; i < MAX_DISKS; i++) begin
            rd_ff[i] <= '0;
            wr_ff[i] <= '0;
         end
      end else begin
         used_ff  <= used_in;
         ready_ff <= ready_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_target_mask    = mask_ff;
   assign rsp_target_slot    = slot_ff;
   assign rsp_echo_request   = echo_req_ff;
   assign rsp_echo_requester = echo_src_ff;
   assign rsp_is_move        = move_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

// ===== design/mrd_checker.sv =====
// Port-level checks on the dispatcher's result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mrd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [mrd_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [mrd_pkg::MASK_W-1:0]    rsp_target_mask,
   input wire logic [mrd_pkg::SLOTO_W-1:0]   rsp_target_slot,
   input wire logic [mrd_pkg::REQID_W-1:0]   rsp_echo_request,
   input wire logic [mrd_pkg::SRCID_W-1:0]   rsp_echo_requester,
   input wire logic                          rsp_is_move,
   input wire logic                          rsp_last
);

   // A stalled result holds its status, targets and flags.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_target_mask) && $stable(rsp_target_slot)
         && $stable(rsp_last) && $stable(rsp_is_move))
      else $error("result changed while stalled");

   // A moved read is never the final result of a request.
   a_move_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_move |-> !rsp_last)
      else $error("move result marked last");

   // A moved read carries no identifiers.
   a_move_no_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_move |-> rsp_echo_request == '0 && rsp_echo_requester == '0)
      else $error("move result carries identifiers");

   // Without a ready disk nothing is targeted.
   a_no_ready_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mrd_pkg::ST_NO_READY |-> rsp_target_mask == '0)
      else $error("targets given with no ready disk");

endmodule

bind mirror_request_dispatcher mrd_checker u_mrd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_target_mask    (rsp_target_mask),
   .rsp_target_slot    (rsp_target_slot),
   .rsp_echo_request   (rsp_echo_request),
   .rsp_echo_requester (rsp_echo_requester),
   .rsp_is_move        (rsp_is_move),
   .rsp_last           (rsp_last)
);

`default_nettype wire

// ===== tb/sv/tb_mirror_request_dispatcher.sv =====
// Self-checking testbench for the mirror request dispatcher.
`timescale 1ns / 1ps

module tb_mirror_request_dispatcher;
   import mrd_pkg::*;

   localparam int SLOTS    = MAX_DISKS_DEFAULT;
   localparam int PEND_MAX = MAX_PENDING_DEFAULT;
   localparam logic [TYPE_W-1:0] REQ_UNDEFINED = 3'd7;
   localparam int HOLD_CYCLES = 150;

   typedef struct packed {
      status_type          status;
      logic [MASK_W-1:0]   mask;
      logic [SLOTO_W-1:0]  slot;
      logic [REQID_W-1:0]  echo_req;
      logic [SRCID_W-1:0]  echo_src;
      logic                is_move;
      logic                last;
   } dispatch_result_type;

   typedef struct packed {
      logic [TYPE_W-1:0]   kind;
      logic [DISK_W-1:0]   disk;
      logic [REQID_W-1:0]  req_id;
      logic [SRCID_W-1:0]  src_id;
      logic                exact;
      status_type          want_status;
      logic [MASK_W-1:0]   want_mask;
      logic [SLOTO_W-1:0]  want_slot;
   } directed_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [TYPE_W-1:0]    req_type;
   logic [DISK_W-1:0]    req_disk_id;
   logic [REQID_W-1:0]   req_transfer_id;
   logic [SRCID_W-1:0]   req_requester_id;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [STATUS_W-1:0]  rsp_status;
   logic [MASK_W-1:0]    rsp_target_mask;
   logic [SLOTO_W-1:0]   rsp_target_slot;
   logic [REQID_W-1:0]   rsp_echo_request;
   logic [SRCID_W-1:0]   rsp_echo_requester;
   logic                 rsp_is_move;
   logic                 rsp_last;

   // Mirror of the disk table.
   bit                   slot_in_use [SLOTS];
   bit                   slot_online [SLOTS];
   logic [DISK_W-1:0]    slot_id     [SLOTS];
   int                   reads_held  [SLOTS];
   int                   writes_held [SLOTS];

   dispatch_result_type  awaited_results[$];
   directed_row_type     directed_rows[$];

   int requests_sent;
   int results_seen;
   int mismatches;
   int moves_seen, no_ready_seen, queue_full_seen, table_full_seen, unknown_seen;
   int hold_left;
   bit hold_done;

   mirror_request_dispatcher DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_disk_id        (req_disk_id),
      .req_transfer_id    (req_transfer_id),
      .req_requester_id   (req_requester_id),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_target_mask    (rsp_target_mask),
      .rsp_target_slot    (rsp_target_slot),
      .rsp_echo_request   (rsp_echo_request),
      .rsp_echo_requester (rsp_echo_requester),
      .rsp_is_move        (rsp_is_move),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Timeout: the dispatcher stopped making progress.");
      $display("*** FAILED ***");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         note_mismatch($sformatf("result %0d field %s is 0x%0h, expected 0x%0h",
                                 results_seen, name, got, want));
   endtask

   function automatic bit quiet_stretch();
      return requests_sent >= 230 && requests_sent < 300;
   endfunction

   function automatic int find_slot(input logic [DISK_W-1:0] disk);
      for (int i = 0; i < SLOTS; i++)
         if (slot_in_use[i] && slot_id[i] == disk) return i;
      return -1;
   endfunction

   function automatic int lightest_slot();
      int best;
      int least;
      best = -1;
      least = 0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_in_use[i] && slot_online[i] &&
             (best < 0 || reads_held[i] + writes_held[i] < least)) begin
            best = i;
            least = reads_held[i] + writes_held[i];
         end
      return best;
   endfunction

   task automatic expect_result(input status_type st, input logic [MASK_W-1:0] mask,
                                input int slot, input logic [REQID_W-1:0] req_id,
                                input logic [SRCID_W-1:0] src_id, input logic mv,
                                input logic lst);
      dispatch_result_type r;
      r.status   = st;
      r.mask     = mask;
      r.slot     = slot[SLOTO_W-1:0];
      r.echo_req = req_id;
      r.echo_src = src_id;
      r.is_move  = mv;
      r.last     = lst;
      awaited_results.push_back(r);
   endtask

   // Updates the table mirror for one request and queues the results it causes.
   task automatic steer_request(input logic [TYPE_W-1:0] kind, input logic [DISK_W-1:0] disk,
                                input logic [REQID_W-1:0] req_id,
                                input logic [SRCID_W-1:0] src_id);
      int s;
      int t;
      int moves;
      bit empty;
      bit full;
      logic [MASK_W-1:0] mask;
      case (kind)
         REQ_ATTACH: begin
            empty = 1'b1;
            s = -1;
            for (int i = 0; i < SLOTS; i++)
               if (slot_in_use[i]) empty = 1'b0;
               else if (s < 0) s = i;
            if (s < 0) begin
               expect_result(ST_TABLE_FULL, '0, 0, req_id, src_id, 1'b0, 1'b1);
            end else begin
               slot_in_use[s] = 1'b1;
               slot_online[s] = empty;
               slot_id[s]     = disk;
               reads_held[s]  = 0;
               writes_held[s] = 0;
               expect_result(ST_OK, MASK_W'(1) << s, s, req_id, src_id, 1'b0, 1'b1);
            end
         end
         REQ_READ: begin
            s = lightest_slot();
            if (s < 0) begin
               expect_result(ST_NO_READY, '0, 0, req_id, src_id, 1'b0, 1'b1);
            end else if (reads_held[s] >= PEND_MAX) begin
               expect_result(ST_QUEUE_FULL, '0, s, req_id, src_id, 1'b0, 1'b1);
            end else begin
               reads_held[s]++;
               expect_result(ST_OK, MASK_W'(1) << s, s, req_id, src_id, 1'b0, 1'b1);
            end
         end
         REQ_WRITE: begin
            mask = '0;
            full = 1'b0;
            for (int i = 0; i < SLOTS; i++)
               if (slot_in_use[i] && slot_online[i]) begin
                  mask[i] = 1'b1;
                  if (writes_held[i] >= PEND_MAX) full = 1'b1;
               end
            if (mask == '0) begin
               expect_result(ST_NO_READY, '0, 0, req_id, src_id, 1'b0, 1'b1);
            end else if (full) begin
               expect_result(ST_QUEUE_FULL, '0, 0, req_id, src_id, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < SLOTS; i++)
                  if (mask[i]) writes_held[i]++;
               expect_result(ST_OK, mask, 0, req_id, src_id, 1'b0, 1'b1);
            end
         end
         REQ_READ_DONE, REQ_WRITE_DONE, REQ_MARK_READY: begin
            s = find_slot(disk);
            if (s < 0) begin
               expect_result(ST_UNKNOWN, '0, 0, req_id, src_id, 1'b0, 1'b1);
            end else begin
               if (kind == REQ_READ_DONE) begin
                  if (reads_held[s] > 0) reads_held[s]--;
               end else if (kind == REQ_WRITE_DONE) begin
                  if (writes_held[s] > 0) writes_held[s]--;
               end else begin
                  slot_online[s] = 1'b1;
               end
               expect_result(ST_OK, '0, s, req_id, src_id, 1'b0, 1'b1);
            end
         end
         REQ_DETACH: begin
            s = find_slot(disk);
            if (s < 0) begin
               expect_result(ST_UNKNOWN, '0, 0, req_id, src_id, 1'b0, 1'b1);
            end else begin
               moves = reads_held[s];
               slot_in_use[s] = 1'b0;
               slot_online[s] = 1'b0;
               reads_held[s]  = 0;
               writes_held[s] = 0;
               for (int m = 0; m < moves; m++) begin
                  t = lightest_slot();
                  if (t < 0) begin
                     expect_result(ST_NO_READY, '0, 0, '0, '0, 1'b1, 1'b0);
                  end else if (reads_held[t] >= PEND_MAX) begin
                     expect_result(ST_QUEUE_FULL, '0, t, '0, '0, 1'b1, 1'b0);
                  end else begin
                     reads_held[t]++;
                     expect_result(ST_OK, MASK_W'(1) << t, t, '0, '0, 1'b1, 1'b0);
                  end
               end
               expect_result(ST_OK, '0, s, req_id, src_id, 1'b0, 1'b1);
            end
         end
         default: expect_result(ST_OK, '0, 0, req_id, src_id, 1'b0, 1'b1);
      endcase
   endtask

   // Offers one request, waits until it is taken, then predicts its results.
   task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [DISK_W-1:0] disk,
                               input logic [REQID_W-1:0] req_id,
                               input logic [SRCID_W-1:0] src_id);
      while (!quiet_stretch() && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_disk_id      <= disk;
      req_transfer_id  <= req_id;
      req_requester_id <= src_id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      steer_request(kind, disk, req_id, src_id);
   endtask

   task automatic add_row(input logic [TYPE_W-1:0] kind, input logic [DISK_W-1:0] disk,
                          input logic [REQID_W-1:0] req_id, input logic [SRCID_W-1:0] src_id,
                          input logic exact, input status_type st,
                          input logic [MASK_W-1:0] mask, input logic [SLOTO_W-1:0] slot);
      directed_row_type row;
      row.kind        = kind;
      row.disk        = disk;
      row.req_id      = req_id;
      row.src_id      = src_id;
      row.exact       = exact;
      row.want_status = st;
      row.want_mask   = mask;
      row.want_slot   = slot;
      directed_rows.push_back(row);
   endtask

   task automatic random_request();
      int pick;
      int s;
      logic [TYPE_W-1:0] kind;
      logic [DISK_W-1:0] disk;
      pick = $urandom_range(0, 99);
      if (pick < 12)      kind = REQ_ATTACH;
      else if (pick < 42) kind = REQ_READ;
      else if (pick < 57) kind = REQ_WRITE;
      else if (pick < 69) kind = REQ_READ_DONE;
      else if (pick < 79) kind = REQ_WRITE_DONE;
      else if (pick < 87) kind = REQ_MARK_READY;
      else if (pick < 95) kind = REQ_DETACH;
      else                kind = REQ_UNDEFINED;
      disk = DISK_W'($urandom);
      if (kind != REQ_ATTACH && $urandom_range(0, 99) < 80) begin
         s = $urandom_range(0, SLOTS - 1);
         for (int i = 0; i < SLOTS; i++)
            if (slot_in_use[(s + i) % SLOTS]) begin
               disk = slot_id[(s + i) % SLOTS];
               break;
            end
      end else if (kind == REQ_ATTACH && $urandom_range(0, 99) < 30) begin
         disk = DISK_W'($urandom_range(0, 3));
      end
      send_request(kind, disk, $urandom, SRCID_W'($urandom_range(0, 255)));
   endtask

   initial begin : result_monitor
      dispatch_result_type want;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_is_move) moves_seen++;
            if (rsp_status == ST_NO_READY)   no_ready_seen++;
            if (rsp_status == ST_QUEUE_FULL) queue_full_seen++;
            if (rsp_status == ST_TABLE_FULL) table_full_seen++;
            if (rsp_status == ST_UNKNOWN)    unknown_seen++;
            if (awaited_results.size() == 0) begin
               note_mismatch($sformatf("result %0d arrived with none outstanding (status %0d)",
                                       results_seen, rsp_status));
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("target_mask", 32'(rsp_target_mask), 32'(want.mask));
               check_field("target_slot", 32'(rsp_target_slot), 32'(want.slot));
               check_field("echo_request", rsp_echo_request, want.echo_req);
               check_field("echo_requester", 32'(rsp_echo_requester), 32'(want.echo_src));
               check_field("is_move", 32'(rsp_is_move), 32'(want.is_move));
               check_field("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && requests_sent >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (reset) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_stretch() || $urandom_range(0, 99) >= 19;
         end
      end
   end

   initial begin : stimulus
      directed_row_type row;
      logic [DISK_W-1:0] disk_a, disk_b, disk_c;
      int s;
      int waited;
      req_valid        <= 1'b0;
      req_type         <= REQ_ATTACH;
      req_disk_id      <= '0;
      req_transfer_id  <= '0;
      req_requester_id <= '0;
      reset            <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      add_row(REQ_READ, 16'h0000, 32'h0000_0000, 8'h00, 1'b1, ST_NO_READY, 8'h00, 3'd0);
      add_row(REQ_WRITE, 16'h0000, 32'h0000_0011, 8'h01, 1'b1, ST_NO_READY, 8'h00, 3'd0);
      add_row(REQ_READ_DONE, 16'h1234, 32'h0000_0022, 8'h02, 1'b1, ST_UNKNOWN, 8'h00, 3'd0);
      add_row(REQ_DETACH, 16'h4321, 32'h0000_0033, 8'h03, 1'b1, ST_UNKNOWN, 8'h00, 3'd0);
      add_row(REQ_ATTACH, 16'hFFFF, 32'h0000_0044, 8'h04, 1'b1, ST_OK, 8'h01, 3'd0);
      add_row(REQ_ATTACH, 16'h0000, 32'h0000_0055, 8'h05, 1'b1, ST_OK, 8'h02, 3'd1);
      add_row(REQ_MARK_READY, 16'h0000, 32'h0000_0066, 8'h06, 1'b1, ST_OK, 8'h00, 3'd1);
      add_row(REQ_MARK_READY, 16'h0000, 32'h0000_0077, 8'h07, 1'b1, ST_OK, 8'h00, 3'd1);
      add_row(REQ_WRITE_DONE, 16'hFFFF, 32'h0000_0088, 8'h08, 1'b1, ST_OK, 8'h00, 3'd0);
      add_row(REQ_READ_DONE, 16'h0000, 32'h0000_0099, 8'h09, 1'b1, ST_OK, 8'h00, 3'd1);
      add_row(REQ_WRITE, 16'h0000, 32'h1000_0000, 8'h10, 1'b0, ST_OK, 8'h00, 3'd0);
      add_row(REQ_READ, 16'h0000, 32'hFFFF_FFFF, 8'hFF, 1'b0, ST_OK, 8'h00, 3'd0);
      add_row(REQ_READ, 16'h0000, 32'h8000_0001, 8'h80, 1'b0, ST_OK, 8'h00, 3'd0);
      add_row(REQ_READ, 16'h0000, 32'h7FFF_FFFE, 8'h7F, 1'b0, ST_OK, 8'h00, 3'd0);
      add_row(REQ_UNDEFINED, 16'hFFFF, 32'hA5A5_5A5A, 8'hC3, 1'b1, ST_OK, 8'h00, 3'd0);
      add_row(REQ_ATTACH, 16'h5555, 32'h0000_0100, 8'h20, 1'b1, ST_OK, 8'h04, 3'd2);
      add_row(REQ_ATTACH, 16'hAAAA, 32'h0000_0101, 8'h21, 1'b1, ST_OK, 8'h08, 3'd3);
      add_row(REQ_ATTACH, 16'h0001, 32'h0000_0102, 8'h22, 1'b1, ST_OK, 8'h10, 3'd4);
      add_row(REQ_ATTACH, 16'h8000, 32'h0000_0103, 8'h23, 1'b1, ST_OK, 8'h20, 3'd5);
      add_row(REQ_ATTACH, 16'h1234, 32'h0000_0104, 8'h24, 1'b1, ST_OK, 8'h40, 3'd6);
      add_row(REQ_ATTACH, 16'h00FF, 32'h0000_0105, 8'h25, 1'b1, ST_OK, 8'h80, 3'd7);
      add_row(REQ_ATTACH, 16'hBEEF, 32'h0000_0106, 8'h26, 1'b1, ST_TABLE_FULL, 8'h00, 3'd0);
      add_row(REQ_DETACH, 16'hFFFF, 32'h0000_0200, 8'h30, 1'b0, ST_OK, 8'h00, 3'd0);
      add_row(REQ_MARK_READY, 16'h5555, 32'h0000_0201, 8'h31, 1'b1, ST_OK, 8'h00, 3'd2);
      add_row(REQ_DETACH, 16'h0000, 32'h0000_0202, 8'h32, 1'b0, ST_OK, 8'h00, 3'd0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.kind, row.disk, row.req_id, row.src_id);
         if (row.exact) begin
            void'(awaited_results.pop_back());
            expect_result(row.want_status, row.want_mask, row.want_slot, row.req_id,
                          row.src_id, 1'b0, 1'b1);
         end
      end

      // Empty the table, then drive one disk to its read and write limits.
      s = 0;
      while (s >= 0) begin
         s = -1;
         for (int i = 0; i < SLOTS; i++)
            if (slot_in_use[i] && s < 0) s = i;
         if (s >= 0)
            send_request(REQ_DETACH, slot_id[s], $urandom, SRCID_W'($urandom_range(0, 255)));
      end
      disk_a = DISK_W'($urandom);
      disk_b = disk_a ^ 16'h8001;
      disk_c = ~disk_a;
      send_request(REQ_ATTACH, disk_a, $urandom, SRCID_W'($urandom_range(0, 255)));
      send_request(REQ_ATTACH, disk_b, $urandom, SRCID_W'($urandom_range(0, 255)));
      for (int i = 0; i < PEND_MAX + 3; i++) begin
         send_request(REQ_READ, DISK_W'($urandom), $urandom, SRCID_W'($urandom_range(0, 255)));
         send_request(REQ_WRITE, DISK_W'($urandom), $urandom, SRCID_W'($urandom_range(0, 255)));
      end
      send_request(REQ_MARK_READY, disk_b, $urandom, SRCID_W'($urandom_range(0, 255)));
      for (int i = 0; i < PEND_MAX + 3; i++)
         send_request(REQ_READ, DISK_W'($urandom), $urandom, SRCID_W'($urandom_range(0, 255)));
      send_request(REQ_WRITE, DISK_W'($urandom), $urandom, SRCID_W'($urandom_range(0, 255)));
      // Moved reads find the surviving disk full, then find no ready disk at all.
      send_request(REQ_DETACH, disk_a, $urandom, SRCID_W'($urandom_range(0, 255)));
      send_request(REQ_ATTACH, disk_c, $urandom, SRCID_W'($urandom_range(0, 255)));
      send_request(REQ_DETACH, disk_b, $urandom, SRCID_W'($urandom_range(0, 255)));
      send_request(REQ_DETACH, disk_c, $urandom, SRCID_W'($urandom_range(0, 255)));

      repeat (75) random_request();
      req_valid <= 1'b0;

      waited = 0;
      while (awaited_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (awaited_results.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
      repeat (16) @(posedge clock);

      $display("Sent %0d requests (directed table, counter saturation, random mix); %0d results.",
               requests_sent, results_seen);
      $display("Moves %0d, no-ready %0d, queue-full %0d, table-full %0d, unknown-disk %0d.",
               moves_seen, no_ready_seen, queue_full_seen, table_full_seen, unknown_seen);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mrd_pkg.sv
design/mrd_front.sv
design/mrd_queue.sv
design/mrd_back.sv
design/mirror_request_dispatcher.sv
design/mrd_checker.sv
tb/sv/tb_mirror_request_dispatcher.sv
